// ===== sv/rrm_pkg.sv =====
// shared constants, types and direction table functions for the radial ray marcher
package rrm_pkg;

    localparam int NUM_RAYS_DEF      = 500;
    localparam int SCREEN_WIDTH_DEF  = 1200;
    localparam int SCREEN_HEIGHT_DEF = 600;
    localparam int FRAC_BITS_DEF     = 16;

    localparam logic [63:0] PI4_Q30 = 64'd843314857;

    localparam int RAY_INDEX_W = 9;
    localparam int PIX_X_W     = 12;
    localparam int PIX_Y_W     = 11;

    localparam int ORIGIN_X_W   = 11;
    localparam int ORIGIN_Y_W   = 10;
    localparam int OBSTACLE_X_W = 11;
    localparam int OBSTACLE_Y_W = 12;
    localparam int RADIUS_W     = 10;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    localparam int ORIGIN_X_RST   = 200;
    localparam int ORIGIN_Y_RST   = 200;
    localparam int OBSTACLE_X_RST = 600;
    localparam int OBSTACLE_Y_RST = 300;
    localparam int RADIUS_RST     = 140;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ORIGIN_X        = 3'd0,
        CFG_ORIGIN_Y        = 3'd1,
        CFG_OBSTACLE_X      = 3'd2,
        CFG_OBSTACLE_Y      = 3'd3,
        CFG_OBSTACLE_RADIUS = 3'd4
    } t_cfg_reg;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } t_req;

    typedef struct packed {
        logic [63:0] s;
        logic [63:0] c;
    } t_sincos;

    // seven term series for sine and cosine, Q0.30 in and out
    function automatic t_sincos series_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] ss;
        logic [63:0] cs;
        t_sincos     res;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1 << 30;
        ss = x;
        cs = tc;
        ts = ((ts * x2) >> 30) / 64'd6;
        tc = ((tc * x2) >> 30) / 64'd2;
        ss = ss - ts;
        cs = cs - tc;
        ts = ((ts * x2) >> 30) / 64'd20;
        tc = ((tc * x2) >> 30) / 64'd12;
        ss = ss + ts;
        cs = cs + tc;
        ts = ((ts * x2) >> 30) / 64'd42;
        tc = ((tc * x2) >> 30) / 64'd30;
        ss = ss - ts;
        cs = cs - tc;
        ts = ((ts * x2) >> 30) / 64'd72;
        tc = ((tc * x2) >> 30) / 64'd56;
        ss = ss + ts;
        cs = cs + tc;
        ts = ((ts * x2) >> 30) / 64'd110;
        tc = ((tc * x2) >> 30) / 64'd90;
        ss = ss - ts;
        cs = cs - tc;
        ts = ((ts * x2) >> 30) / 64'd156;
        tc = ((tc * x2) >> 30) / 64'd132;
        ss = ss + ts;
        cs = cs + tc;
        res.s = ss;
        res.c = cs;
        return res;
    endfunction

    // round half up from Q0.30 to frac fraction bits
    function automatic logic [63:0] round_q30(input logic [63:0] v, input int frac);
        return (v + (64'd1 << (29 - frac))) >> (30 - frac);
    endfunction

endpackage

// ===== sv/rrm_dir_rom.sv =====
// direction rom: cosine and sine of each ray angle, registered read
module rrm_dir_rom #(
    parameter int NUM_RAYS  = rrm_pkg::NUM_RAYS_DEF,
    parameter int FRAC_BITS = rrm_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [rrm_pkg::RAY_INDEX_W-1:0]      i_addr,
    output logic signed [FRAC_BITS+1:0]          o_dx,
    output logic signed [FRAC_BITS+1:0]          o_dy
);

    localparam int DIR_W = FRAC_BITS + 2;
    localparam int IDX_N = 2 ** rrm_pkg::RAY_INDEX_W;

    logic signed [DIR_W-1:0] tab_dx [IDX_N];
    logic signed [DIR_W-1:0] tab_dy [IDX_N];
    logic signed [DIR_W-1:0] r_dx;
    logic signed [DIR_W-1:0] r_dy;

    for (genvar g = 0; g < IDX_N; g++) begin : g_entry
        localparam int R   = g % NUM_RAYS;
        localparam int T   = 8 * R;
        localparam int OCT = T / NUM_RAYS;
        localparam int REM = T % NUM_RAYS;
        localparam int PH  = (OCT % 2 == 1) ? NUM_RAYS - REM : REM;
        localparam int QD  = (OCT / 2) % 4;
        localparam logic [63:0] X =
            (64'(PH) * rrm_pkg::PI4_Q30 + 64'(NUM_RAYS / 2)) / 64'(NUM_RAYS);
        localparam rrm_pkg::t_sincos SC = rrm_pkg::series_q30(X);
        localparam logic [63:0] S  = rrm_pkg::round_q30(SC.s, FRAC_BITS);
        localparam logic [63:0] C  = rrm_pkg::round_q30(SC.c, FRAC_BITS);
        localparam logic signed [DIR_W-1:0] SB = (OCT % 2 == 1) ? DIR_W'(C) : DIR_W'(S);
        localparam logic signed [DIR_W-1:0] CB = (OCT % 2 == 1) ? DIR_W'(S) : DIR_W'(C);

        assign tab_dx[g] = (QD == 0) ? CB : (QD == 1) ? -SB : (QD == 2) ? -CB : SB;
        assign tab_dy[g] = (QD == 0) ? SB : (QD == 1) ? CB : (QD == 2) ? -SB : -CB;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= tab_dx[i_addr];
            r_dy <= tab_dy[i_addr];
        end
    end

    assign o_dx = r_dx;
    assign o_dy = r_dy;

endmodule

// ===== sv/radial_ray_marcher_circle_occluder.sv =====
// top level of the radial ray marcher with a circular occluder
//
// Input channel (i_valid / o_stall) carries items: a start item (req_type 0) loads
// the ray position with the origin registers and fetches the ray direction from the
// direction rom; a step item (req_type 1) advances the ray one unit and yields one
// result on the output channel (o_valid / i_stall) while the ray runs. Start items
// and steps with no running ray give no result.
// A result carries the truncated pixel corner, a last flag (off screen or inside the
// occluder) and a hit flag. After a last result further steps give nothing.
// Throughput: one item per cycle while no stall holds the pipeline, set by the single
// position add per step; the pipeline is input stage, distance stage,
// square-and-compare stage, output register. When the receiver stalls, the result
// holds in the output register and the stages behind it keep filling; o_stall rises
// only once all stages hold items. Configuration writes (i_cfg_valid, always ready)
// are the user's to make only while the block is idle, which it does not enforce.
// Reset clears all stages, drops the running ray and loads the register defaults.
module radial_ray_marcher_circle_occluder #(
    parameter int NUM_RAYS      = rrm_pkg::NUM_RAYS_DEF,
    parameter int SCREEN_WIDTH  = rrm_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = rrm_pkg::SCREEN_HEIGHT_DEF,
    parameter int FRAC_BITS     = rrm_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_req_type,
    input  logic [rrm_pkg::RAY_INDEX_W-1:0]      i_ray_index,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [rrm_pkg::PIX_X_W-1:0]   o_pixel_x,
    output logic signed [rrm_pkg::PIX_Y_W-1:0]   o_pixel_y,
    output logic                                 o_ray_last,
    output logic                                 o_ray_hit,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rrm_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [rrm_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int POS_W  = FRAC_BITS + 14;
    localparam int DIR_W  = FRAC_BITS + 2;
    localparam int DIST_W = POS_W + 1;
    localparam int RR_W   = rrm_pkg::RADIUS_W + FRAC_BITS;
    localparam int R2_W   = 2 * rrm_pkg::RADIUS_W;
    localparam int SQ_W   = 2 * RR_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int PX_W   = rrm_pkg::PIX_X_W;
    localparam int PY_W   = rrm_pkg::PIX_Y_W;

    localparam logic signed [POS_W-1:0] X_MAX = POS_W'(longint'(SCREEN_WIDTH) << FRAC_BITS);
    localparam logic signed [POS_W-1:0] Y_MAX = POS_W'(longint'(SCREEN_HEIGHT) << FRAC_BITS);

    // configuration registers
    logic [rrm_pkg::ORIGIN_X_W-1:0]          r_origin_x;
    logic [rrm_pkg::ORIGIN_Y_W-1:0]          r_origin_y;
    logic [rrm_pkg::OBSTACLE_X_W-1:0]        r_obstacle_x;
    logic signed [rrm_pkg::OBSTACLE_Y_W-1:0] r_obstacle_y;
    logic [rrm_pkg::RADIUS_W-1:0]            r_obstacle_radius;

    // pipeline control
    logic r_a_valid, r_a_start;
    logic r_b_valid, r_b_start;
    logic r_c_valid, r_c_start;
    logic r_out_valid;
    logic r_active;
    logic out_free, c_move, c_free, b_move, b_free, a_move, a_free;
    logic in_accept, in_start;

    // datapath
    logic signed [DIR_W-1:0]  dir_dx, dir_dy;
    logic signed [POS_W-1:0]  r_pos_x, r_pos_y;
    logic signed [POS_W-1:0]  n_pos_x, n_pos_y;
    logic signed [DIST_W-1:0] ex, ey, obs_x_fix, obs_y_fix;
    logic [DIST_W-1:0]        ux, uy;
    logic [RR_W-1:0]          rr;
    logic [POS_W-1:0]         mag_x, mag_y, tr_x, tr_y, pf_x, pf_y;
    logic                     near, off;
    logic [RR_W-1:0]          r_c_ux, r_c_uy;
    logic [R2_W-1:0]          r_c_r2;
    logic                     r_c_near, r_c_off;
    logic [PX_W-1:0]          r_c_pix_x;
    logic [PY_W-1:0]          r_c_pix_y;
    logic [SQ_W-1:0]          sq_x, sq_y;
    logic [SUM_W-1:0]         sq_sum, rr2;
    logic                     hit, last;
    logic signed [PX_W-1:0]   r_pixel_x;
    logic signed [PY_W-1:0]   r_pixel_y;
    logic                     r_ray_last, r_ray_hit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x        <= rrm_pkg::ORIGIN_X_W'(rrm_pkg::ORIGIN_X_RST);
            r_origin_y        <= rrm_pkg::ORIGIN_Y_W'(rrm_pkg::ORIGIN_Y_RST);
            r_obstacle_x      <= rrm_pkg::OBSTACLE_X_W'(rrm_pkg::OBSTACLE_X_RST);
            r_obstacle_y      <= rrm_pkg::OBSTACLE_Y_W'(rrm_pkg::OBSTACLE_Y_RST);
            r_obstacle_radius <= rrm_pkg::RADIUS_W'(rrm_pkg::RADIUS_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (rrm_pkg::t_cfg_reg'(i_cfg_index))
                rrm_pkg::CFG_ORIGIN_X: begin
                    r_origin_x <= i_cfg_data[rrm_pkg::ORIGIN_X_W-1:0];
                end
                rrm_pkg::CFG_ORIGIN_Y: begin
                    r_origin_y <= i_cfg_data[rrm_pkg::ORIGIN_Y_W-1:0];
                end
                rrm_pkg::CFG_OBSTACLE_X: begin
                    r_obstacle_x <= i_cfg_data[rrm_pkg::OBSTACLE_X_W-1:0];
                end
                rrm_pkg::CFG_OBSTACLE_Y: begin
                    r_obstacle_y <= $signed(i_cfg_data[rrm_pkg::OBSTACLE_Y_W-1:0]);
                end
                rrm_pkg::CFG_OBSTACLE_RADIUS: begin
                    r_obstacle_radius <= i_cfg_data[rrm_pkg::RADIUS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // stage advance, each stage moves when the one ahead frees up
    assign out_free  = !r_out_valid || !i_stall;
    assign c_move    = r_c_valid && out_free;
    assign c_free    = !r_c_valid || c_move;
    assign b_move    = r_b_valid && c_free;
    assign b_free    = !r_b_valid || b_move;
    assign a_move    = r_a_valid && b_free;
    assign a_free    = !r_a_valid || a_move;
    assign o_stall   = !a_free;
    assign in_accept = i_valid && a_free;
    assign in_start  = (rrm_pkg::t_req'(i_req_type) == rrm_pkg::REQ_START);

    rrm_dir_rom #(
        .NUM_RAYS  (NUM_RAYS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dir_rom (
        .i_clk  (i_clk),
        .i_en   (in_accept && in_start),
        .i_addr (i_ray_index),
        .o_dx   (dir_dx),
        .o_dy   (dir_dy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_valid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (c_free) begin
                r_c_valid <= r_b_valid;
            end
            if (out_free) begin
                r_out_valid <= c_move && !r_c_start && r_active;
            end
            if (c_move) begin
                if (r_c_start) begin
                    r_active <= 1'b1;
                end else if (last) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // input stage: position loads the origin on a start and advances on a step as its item moves on
    always_comb begin
        if (r_a_start) begin
            n_pos_x = $signed(POS_W'(r_origin_x) << FRAC_BITS);
            n_pos_y = $signed(POS_W'(r_origin_y) << FRAC_BITS);
        end else begin
            n_pos_x = r_pos_x + POS_W'(dir_dx);
            n_pos_y = r_pos_y + POS_W'(dir_dy);
        end
    end

    // distance stage
    always_comb begin
        obs_x_fix = $signed(DIST_W'(r_obstacle_x) << FRAC_BITS);
        obs_y_fix = DIST_W'(r_obstacle_y) <<< FRAC_BITS;
        ex        = DIST_W'(r_pos_x) - obs_x_fix;
        ey        = DIST_W'(r_pos_y) - obs_y_fix;
        ux        = ex[DIST_W-1] ? DIST_W'(-ex) : DIST_W'(ex);
        uy        = ey[DIST_W-1] ? DIST_W'(-ey) : DIST_W'(ey);
        rr        = RR_W'(r_obstacle_radius) << FRAC_BITS;
        near      = (ux < DIST_W'(rr)) && (uy < DIST_W'(rr));
        off       = r_pos_x[POS_W-1] || (r_pos_x > X_MAX) ||
                    r_pos_y[POS_W-1] || (r_pos_y > Y_MAX);
        mag_x     = r_pos_x[POS_W-1] ? POS_W'(-r_pos_x) : POS_W'(r_pos_x);
        mag_y     = r_pos_y[POS_W-1] ? POS_W'(-r_pos_y) : POS_W'(r_pos_y);
        tr_x      = mag_x >> FRAC_BITS;
        tr_y      = mag_y >> FRAC_BITS;
        pf_x      = r_pos_x[POS_W-1] ? POS_W'(-tr_x) : tr_x;
        pf_y      = r_pos_y[POS_W-1] ? POS_W'(-tr_y) : tr_y;
    end

    // square and compare stage
    always_comb begin
        sq_x   = SQ_W'(r_c_ux) * SQ_W'(r_c_ux);
        sq_y   = SQ_W'(r_c_uy) * SQ_W'(r_c_uy);
        sq_sum = SUM_W'(sq_x) + SUM_W'(sq_y);
        rr2    = SUM_W'(r_c_r2) << (2 * FRAC_BITS);
        hit    = r_c_near && (sq_sum < rr2);
        last   = r_c_off || hit;
    end

    always_ff @(posedge i_clk) begin
        if (a_free) begin
            r_a_start <= in_start;
        end
        if (a_move) begin
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_b_start <= r_a_start;
        end
        if (b_move) begin
            r_c_start <= r_b_start;
            r_c_ux    <= ux[RR_W-1:0];
            r_c_uy    <= uy[RR_W-1:0];
            r_c_r2    <= R2_W'(r_obstacle_radius) * R2_W'(r_obstacle_radius);
            r_c_near  <= near;
            r_c_off   <= off;
            r_c_pix_x <= pf_x[PX_W-1:0];
            r_c_pix_y <= pf_y[PY_W-1:0];
        end
        if (c_move) begin
            r_pixel_x  <= $signed(r_c_pix_x);
            r_pixel_y  <= $signed(r_c_pix_y);
            r_ray_last <= last;
            r_ray_hit  <= hit;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_pixel_x  = r_pixel_x;
    assign o_pixel_y  = r_pixel_y;
    assign o_ray_last = r_ray_last;
    assign o_ray_hit  = r_ray_hit;

    // ray ends only through a step leaving the last stage
    a_active_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_active) && $past(i_rst_n) |-> $past(c_move && !r_c_start))
        else $error("ray dropped without an ending step");

    // a result that does not end the ray leaves it running
    a_run_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ray_last |-> r_active)
        else $error("ray not running after a non-final result");

    a_hit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ray_hit |-> o_ray_last)
        else $error("hit result not flagged last");

endmodule

// ===== test/radial_ray_marcher_circle_occluder_test.sv =====
// self-checking testbench for the radial ray marcher: predicts every step result and checks it
module radial_ray_marcher_circle_occluder_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic [rrm_pkg::PIX_X_W-1:0] px;
        logic [rrm_pkg::PIX_Y_W-1:0] py;
        logic                        last;
        logic                        hit;
    } t_step_result;

    localparam int   NUM_RAYS      = rrm_pkg::NUM_RAYS_DEF;
    localparam int   SCREEN_W      = rrm_pkg::SCREEN_WIDTH_DEF;
    localparam int   SCREEN_H      = rrm_pkg::SCREEN_HEIGHT_DEF;
    localparam int   FRAC          = rrm_pkg::FRAC_BITS_DEF;
    localparam int   IDX_W         = rrm_pkg::RAY_INDEX_W;
    localparam t_u64 EIGHTH_TURN_Q30 = 64'd843314857;
    localparam int   IDLE_PCT      = 11;
    localparam int   DRAIN_CYCLES  = 8;
    localparam int   HOLD_LEN      = 80;
    localparam int   RANDOM_ITEMS  = 1200;
    localparam int   PHASES        = 6;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_valid     = 1'b0;
    logic                               o_stall;
    logic                               i_req_type  = 1'b0;
    logic [IDX_W-1:0]                   i_ray_index = '0;
    logic                               o_valid;
    logic                               i_stall     = 1'b0;
    logic signed [rrm_pkg::PIX_X_W-1:0] o_pixel_x;
    logic signed [rrm_pkg::PIX_Y_W-1:0] o_pixel_y;
    logic                               o_ray_last;
    logic                               o_ray_hit;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [rrm_pkg::CFG_INDEX_W-1:0]    i_cfg_index = '0;
    logic [rrm_pkg::CFG_DATA_W-1:0]     i_cfg_data  = '0;

    radial_ray_marcher_circle_occluder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req_type  (i_req_type),
        .i_ray_index (i_ray_index),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_ray_last  (o_ray_last),
        .o_ray_hit   (o_ray_hit),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // register copies
    int cfg_org_x  = rrm_pkg::ORIGIN_X_RST;
    int cfg_org_y  = rrm_pkg::ORIGIN_Y_RST;
    int cfg_obs_x  = rrm_pkg::OBSTACLE_X_RST;
    int cfg_obs_y  = rrm_pkg::OBSTACLE_Y_RST;
    int cfg_radius = rrm_pkg::RADIUS_RST;

    // ray state
    longint ray_px   = 0;
    longint ray_py   = 0;
    int     ray_dir  = 0;
    bit     ray_live = 1'b0;

    longint step_dx [NUM_RAYS];
    longint step_dy [NUM_RAYS];

    t_step_result pending [$];
    t_step_result want;

    bit gaps_on      = 1'b1;
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;

    int mismatches   = 0;
    int results_seen = 0;
    int hits_seen    = 0;
    int rays_started = 0;
    int useful_items = 0;
    int cfg_writes   = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("radial_ray_marcher_circle_occluder: mismatch");
        $finish;
    end

    // unit direction of ray r, Q.FRAC
    function automatic void ray_heading(input int r, output longint hx, output longint hy);
        int     t, oct, rem, ph, k;
        t_u64   ang, ang2, ts, tc;
        longint sn, cs, sb, cb;
        t   = 8 * r;
        oct = t / NUM_RAYS;
        rem = t % NUM_RAYS;
        ph  = oct[0] ? NUM_RAYS - rem : rem;
        ang  = (t_u64'(ph) * EIGHTH_TURN_Q30 + t_u64'(NUM_RAYS / 2)) / t_u64'(NUM_RAYS);
        ang2 = (ang * ang) >> 30;
        ts   = ang;
        tc   = t_u64'(1) << 30;
        sn   = longint'(ts);
        cs   = longint'(tc);
        for (k = 1; k <= 6; k++) begin
            ts = ((ts * ang2) >> 30) / t_u64'(2 * k * (2 * k + 1));
            tc = ((tc * ang2) >> 30) / t_u64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                sn = sn - longint'(ts);
                cs = cs - longint'(tc);
            end else begin
                sn = sn + longint'(ts);
                cs = cs + longint'(tc);
            end
        end
        sn = (sn + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
        cs = (cs + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
        if (oct[0]) begin
            sb = cs;
            cb = sn;
        end else begin
            sb = sn;
            cb = cs;
        end
        case (oct[2:1])
            2'd0: begin
                hx = cb;
                hy = sb;
            end
            2'd1: begin
                hx = -sb;
                hy = cb;
            end
            2'd2: begin
                hx = -cb;
                hy = -sb;
            end
            default: begin
                hx = sb;
                hy = -cb;
            end
        endcase
    endfunction

    function automatic longint trunc_pixel(input longint p);
        return (p >= 0) ? (p >>> FRAC) : -((-p) >>> FRAC);
    endfunction

    // advance the ray state by one item, returns 1 when a result is due
    function automatic bit march_ray(input rrm_pkg::t_req kind, input logic [IDX_W-1:0] idx,
                                     output t_step_result res);
        longint unit_len, ex, ey, rr, ux, uy;
        bit     off, hit;
        unit_len = longint'(1) << FRAC;
        res      = '0;
        if (kind == rrm_pkg::REQ_START) begin
            ray_dir  = int'(idx) % NUM_RAYS;
            ray_px   = longint'(cfg_org_x) * unit_len;
            ray_py   = longint'(cfg_org_y) * unit_len;
            ray_live = 1'b1;
            return 1'b0;
        end
        if (!ray_live)
            return 1'b0;
        ray_px = ray_px + step_dx[ray_dir];
        ray_py = ray_py + step_dy[ray_dir];
        off = ray_px < 0 || ray_px > longint'(SCREEN_W) * unit_len ||
              ray_py < 0 || ray_py > longint'(SCREEN_H) * unit_len;
        ex  = ray_px - longint'(cfg_obs_x) * unit_len;
        ey  = ray_py - longint'(cfg_obs_y) * unit_len;
        rr  = longint'(cfg_radius) * unit_len;
        ux  = (ex < 0) ? -ex : ex;
        uy  = (ey < 0) ? -ey : ey;
        hit = ux < rr && uy < rr && (ux * ux + uy * uy < rr * rr);
        if (off || hit)
            ray_live = 1'b0;
        res.px   = rrm_pkg::PIX_X_W'(trunc_pixel(ray_px));
        res.py   = rrm_pkg::PIX_Y_W'(trunc_pixel(ray_py));
        res.last = off || hit;
        res.hit  = hit;
        return 1'b1;
    endfunction

    task automatic send_item(input rrm_pkg::t_req kind, input logic [IDX_W-1:0] idx);
        t_step_result res;
        bit           made;
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_req_type  <= kind;
        i_ray_index <= idx;
        do @(posedge i_clk); while (o_stall);
        made = march_ray(kind, idx, res);
        if (made) begin
            pending.push_back(res);
            hits_seen += res.hit;
        end
        if (kind == rrm_pkg::REQ_START)
            rays_started++;
        if (kind == rrm_pkg::REQ_START || made)
            useful_items++;
    endtask

    task automatic send_step();
        send_item(rrm_pkg::REQ_STEP, IDX_W'($urandom_range(511)));
    endtask

    task automatic send_start(input int idx);
        send_item(rrm_pkg::REQ_START, IDX_W'(idx));
    endtask

    // stop offering and let every outstanding result and any silent item clear
    task automatic quiesce();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input rrm_pkg::t_cfg_reg sel, input int value);
        logic [rrm_pkg::CFG_DATA_W-1:0] data;
        data = value[rrm_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (sel)
            rrm_pkg::CFG_ORIGIN_X:
                cfg_org_x  = int'(data[rrm_pkg::ORIGIN_X_W-1:0]);
            rrm_pkg::CFG_ORIGIN_Y:
                cfg_org_y  = int'(data[rrm_pkg::ORIGIN_Y_W-1:0]);
            rrm_pkg::CFG_OBSTACLE_X:
                cfg_obs_x  = int'(data[rrm_pkg::OBSTACLE_X_W-1:0]);
            rrm_pkg::CFG_OBSTACLE_Y:
                cfg_obs_y  = int'($signed(data[rrm_pkg::OBSTACLE_Y_W-1:0]));
            rrm_pkg::CFG_OBSTACLE_RADIUS:
                cfg_radius = int'(data[rrm_pkg::RADIUS_W-1:0]);
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_scene(input int ox, input int oy, input int bx, input int by,
                             input int rad);
        write_reg(rrm_pkg::CFG_ORIGIN_X, ox);
        write_reg(rrm_pkg::CFG_ORIGIN_Y, oy);
        write_reg(rrm_pkg::CFG_OBSTACLE_X, bx);
        write_reg(rrm_pkg::CFG_OBSTACLE_Y, by);
        write_reg(rrm_pkg::CFG_OBSTACLE_RADIUS, rad);
    endtask

    always @(negedge i_clk) begin
        if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_LEN;
            i_stall      <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d last=%0b hit=%0b",
                             o_pixel_x, o_pixel_y, o_ray_last, o_ray_hit);
            end else begin
                want = pending.pop_front();
                results_seen++;
                if (o_pixel_x !== want.px || o_pixel_y !== want.py ||
                    o_ray_last !== want.last || o_ray_hit !== want.hit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"step %0d: expected x=%0d y=%0d last=%0b hit=%0b, ",
                                  "got %0d %0d %0b %0b"},
                                 results_seen, $signed(want.px), $signed(want.py), want.last,
                                 want.hit, o_pixel_x, o_pixel_y, o_ray_last, o_ray_hit);
                end
            end
        end
    end

    task automatic test_idle_step();
        send_step();
    endtask

    task automatic test_headings();
        send_start(0);
        send_step();
        send_start(63);
        send_step();
        send_start(125);
        send_step();
        send_start(250);
        send_step();
        send_start(375);
        send_step();
        // wraps to ray 11
        send_start(511);
        send_step();
    endtask

    task automatic test_midray_config();
        send_start(0);
        send_step();
        quiesce();
        // obstacle moves onto the ray path with zero radius, origin moves under the ray
        set_scene(0, 0, 202, 200, 0);
        send_step();
    endtask

    task automatic test_edges();
        quiesce();
        write_reg(rrm_pkg::CFG_ORIGIN_X, 2047);
        write_reg(rrm_pkg::CFG_ORIGIN_Y, 1023);
        send_start(5);
        send_step();
        quiesce();
        write_reg(rrm_pkg::CFG_ORIGIN_X, 0);
        write_reg(rrm_pkg::CFG_ORIGIN_Y, 300);
        send_start(250);
        send_step();
        quiesce();
        set_scene(200, 200, 202, 200, 1);
        send_start(0);
        send_step();
        send_step();
        send_step();
    endtask

    task automatic test_back_pressure();
        quiesce();
        set_scene(0, 300, 0, -600, 0);
        gaps_on = 1'b0;
        send_start(0);
        holds_asked++;
        repeat (200) send_step();
        quiesce();
        repeat (100) send_step();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_rays();
        int phase, target, budget;
        for (phase = 0; phase < PHASES; phase++) begin
            quiesce();
            if (phase == 0)
                set_scene(0, 0, 0, -600, 0);
            else if (phase == 1)
                set_scene(1199, 599, 1199, 1200, 600);
            else
                set_scene($urandom_range(1199), $urandom_range(599), $urandom_range(1199),
                          int'($urandom_range(1800)) - 600, $urandom_range(600));
            target = useful_items + RANDOM_ITEMS / PHASES;
            while (useful_items < target) begin
                send_item(rrm_pkg::REQ_START, IDX_W'($urandom_range(511)));
                budget = ($urandom_range(99) < 8) ? 2000 : $urandom_range(1, 80);
                while (ray_live && budget > 0) begin
                    send_step();
                    budget--;
                end
                if ($urandom_range(99) < 20)
                    repeat ($urandom_range(1, 3)) send_step();
                if ($urandom_range(99) < 5)
                    quiesce();
            end
        end
    endtask

    initial begin
        int r;
        for (r = 0; r < NUM_RAYS; r++)
            ray_heading(r, step_dx[r], step_dy[r]);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_step();
        test_headings();
        test_midray_config();
        test_edges();
        test_back_pressure();
        test_random_rays();

        quiesce();
        $display("%0d rays over %0d register writes, %0d step results checked, %0d hits",
                 rays_started, cfg_writes, results_seen, hits_seen);
        $display("%0d mismatches, %0d results still awaited", mismatches, pending.size());
        if (mismatches == 0 && pending.size() == 0)
            $display("radial_ray_marcher_circle_occluder: match");
        else
            $display("radial_ray_marcher_circle_occluder: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rrm_pkg.sv
sv/rrm_dir_rom.sv
sv/radial_ray_marcher_circle_occluder.sv
test/radial_ray_marcher_circle_occluder_test.sv
